/* src/ffb_pkg.sv */
// ----------------------------------------------------------------------------
// ffb_pkg
// shared constants and types for the finite fraction check
// ----------------------------------------------------------------------------
package ffb_pkg;
  localparam int Width = 32;
  localparam int DenW = Width - 1;
  localparam int CntW = $clog2(Width + 1);
  localparam logic [5:0] RadixMin = 6'd2;
  localparam logic [5:0] RadixMax = 6'd36;
  localparam logic [5:0] RadixReset = 6'd10;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

/* src/ffb_div.sv */
// ----------------------------------------------------------------------------
// ffb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ffb_div import ffb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output div_ctl_t         ctl,
  output logic             done,
  output logic [Width-1:0] quot,
  output logic [Width-1:0] rem
);
  logic [Width-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [Width:0] sh, diff;

  always_comb begin
    sh = {r_r, q_r[Width-1]};
    diff = sh - {1'b0, d_r};
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor;
      cnt_nxt = CntW'(Width); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[Width]) begin
        r_nxt = sh[Width-1:0];
        q_nxt = {q_r[Width-2:0], 1'b0};
      end else begin
        r_nxt = diff[Width-1:0];
        q_nxt = {q_r[Width-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem = r_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(busy_r)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> busy_r || done) else $error("busy dropped");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("counter underflow");
endmodule

/* src/finite_fraction_in_base_check.sv */
// ----------------------------------------------------------------------------
// finite_fraction_in_base_check
// reduces a fraction by its gcd and tests finiteness in the radix
// ----------------------------------------------------------------------------
// each division runs on the shared bit-serial divider; an item takes one
// division per euclid step, two to reduce the fraction, then the radix steps;
// one item at a time
// result held in an output register; next input accepted while it waits
// synchronous active-low reset; radix resets to 10
module finite_fraction_in_base_check import ffb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [5:0]       cfg_radix,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_numerator,
  input  logic [DenW-1:0]  in_denominator,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_finite,
  output logic [Width-1:0] out_reduced_numerator,
  output logic [DenW-1:0]  out_reduced_denominator
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GCD   = 9'b000000010,
    S_GW    = 9'b000000100,
    S_NUM   = 9'b000001000,
    S_DEN   = 9'b000010000,
    S_RGCD  = 9'b000100000,
    S_RGW   = 9'b001000000,
    S_RDIV  = 9'b010000000,
    S_DONE  = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  logic [5:0] radix_r;
  logic [Width-1:0] num_r, num_nxt, den_r, den_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [Width-1:0] g_r, g_nxt, rest_r, rest_nxt, rnum_r, rnum_nxt;
  logic [Width-1:0] dvd, dvs, quot, rem;
  logic start, done, ov_r, ov_nxt, fin_r, fin_nxt;
  logic [5:0] base;
  div_ctl_t dctl;

  always_comb begin
    base = radix_r;
    if (radix_r < RadixMin) base = RadixMin;
    if (radix_r > RadixMax) base = RadixMax;
  end

  ffb_div u_div (.clk, .rst_n, .start, .dividend(dvd), .divisor(dvs),
    .ctl(dctl), .done, .quot, .rem);

  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r; num_nxt = num_r; den_nxt = den_r; a_nxt = a_r; b_nxt = b_r;
    g_nxt = g_r; rest_nxt = rest_r; rnum_nxt = rnum_r; ov_nxt = ov_r;
    fin_nxt = fin_r; start = 1'b0; dvd = b_r; dvs = a_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid && in_ready) begin
        num_nxt = in_numerator[Width-1] ? (~in_numerator + 1'b1) : in_numerator;
        den_nxt = {1'b0, in_denominator};
        a_nxt = num_nxt; b_nxt = den_nxt;
        st_nxt = S_GCD;
      end
      S_GCD: if (a_r == '0) begin
        g_nxt = (b_r == '0) ? Width'(1) : b_r;
        start = 1'b1; dvd = num_r; dvs = g_nxt;
        st_nxt = S_NUM;
      end else begin
        start = 1'b1; st_nxt = S_GW;
      end
      S_GW: if (done) begin
        b_nxt = a_r; a_nxt = rem; st_nxt = S_GCD;
      end
      S_NUM: if (done) begin
        rnum_nxt = quot; start = 1'b1; dvd = den_r; dvs = g_r; st_nxt = S_DEN;
      end
      S_DEN: if (done) begin
        rest_nxt = quot; den_nxt = quot;
        if (quot == '0) begin
          fin_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          a_nxt = Width'(base); b_nxt = quot; st_nxt = S_RGCD;
        end
      end
      S_RGCD: if (a_r == '0) begin
        if (b_r <= Width'(1)) begin
          fin_nxt = (rest_r == Width'(1)); st_nxt = S_DONE;
        end else begin
          start = 1'b1; dvd = rest_r; dvs = b_r; st_nxt = S_RDIV;
        end
      end else begin
        start = 1'b1; st_nxt = S_RGW;
      end
      S_RGW: if (done) begin
        b_nxt = a_r; a_nxt = rem; st_nxt = S_RGCD;
      end
      S_RDIV: if (done) begin
        rest_nxt = quot; a_nxt = Width'(base); b_nxt = quot; st_nxt = S_RGCD;
      end
      S_DONE: if (!ov_r || out_ready) begin
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt; den_r <= den_nxt; a_r <= a_nxt; b_r <= b_nxt;
    g_r <= g_nxt; rest_r <= rest_nxt; rnum_r <= rnum_nxt; fin_r <= fin_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; radix_r <= RadixReset;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      if (cfg_we) radix_r <= cfg_radix;
    end
  end

  logic             of_r;
  logic [Width-1:0] on_r;
  logic [DenW-1:0]  od_r;
  always_ff @(posedge clk) begin
    if (st_r == S_DONE && (!ov_r || out_ready)) begin
      of_r <= fin_r; on_r <= rnum_r; od_r <= den_r[DenW-1:0];
    end
  end

  assign out_valid = ov_r;
  assign out_finite = of_r;
  assign out_reduced_numerator = on_r;
  assign out_reduced_denominator = od_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> st_r == S_GCD) else $error("accept lost");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !dctl.busy || done) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(on_r))
    else $error("result dropped");
endmodule

/* verif/finite_fraction_in_base_check_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// finite_fraction_in_base_check_tb
// checks gcd reduction and finiteness of fractions in several radices; a queue
// driver feeds directed and random fractions, a monitor compares each result
// beat with a predicted one, radix changes happen only while the block idles
// ----------------------------------------------------------------------------
module finite_fraction_in_base_check_tb;
  import ffb_pkg::*;

  typedef struct {
    logic [Width-1:0] num;
    logic [DenW-1:0]  den;
    logic             set_radix;
    logic [5:0]       radix;
    logic             drain;
  } fraction_t;

  typedef struct {
    logic             finite;
    logic [Width-1:0] rnum;
    logic [DenW-1:0]  rden;
  } reduced_t;

  localparam int StallLimit = 400000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [5:0]       cfg_radix;
  logic             in_valid;
  logic             in_ready;
  logic [Width-1:0] in_numerator;
  logic [DenW-1:0]  in_denominator;
  logic             out_valid;
  logic             out_ready;
  logic             out_finite;
  logic [Width-1:0] out_reduced_numerator;
  logic [DenW-1:0]  out_reduced_denominator;

  fraction_t pending_fractions[$];
  reduced_t  expected_fractions[$];
  logic [5:0] radix_now;
  int  in_gap, out_gap, drain_wait, idle_cycles;
  bit  failed, feeding_done, finishing;

  finite_fraction_in_base_check dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_radix(cfg_radix),
    .in_valid(in_valid), .in_ready(in_ready), .in_numerator(in_numerator),
    .in_denominator(in_denominator), .out_valid(out_valid), .out_ready(out_ready),
    .out_finite(out_finite), .out_reduced_numerator(out_reduced_numerator),
    .out_reduced_denominator(out_reduced_denominator)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (a != 0) begin
      r = b % a;
      b = a;
      a = r;
    end
    return b;
  endfunction

  function automatic reduced_t reduce_fraction(logic [Width-1:0] num, logic [DenW-1:0] den,
                                               logic [5:0] radix);
    reduced_t    res;
    logic [63:0] mag, g, base, rest, c;
    mag = num[Width-1] ? {32'd0, -num} : {32'd0, num};
    g = euclid(mag, {33'd0, den});
    if (g == 0) g = 1;
    res.rnum = Width'(mag / g);
    res.rden = DenW'({33'd0, den} / g);
    base = (radix < RadixMin) ? RadixMin : (radix > RadixMax) ? RadixMax : radix;
    rest = {33'd0, res.rden};
    if (rest == 0) begin
      res.finite = 1'b0;
    end else begin
      c = euclid(base, rest);
      while (c > 1) begin
        rest = rest / c;
        c = euclid(base, rest);
      end
      res.finite = (rest == 1);
    end
    return res;
  endfunction

  function automatic fraction_t plain(logic [Width-1:0] num, logic [DenW-1:0] den);
    fraction_t f;
    f.num = num;
    f.den = den;
    f.set_radix = 1'b0;
    f.radix = 6'd0;
    f.drain = 1'b0;
    return f;
  endfunction

  function automatic logic [DenW-1:0] smooth_den();
    logic [63:0] d;
    int n;
    d = 1;
    n = $urandom_range(0, 8);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: d = d * 2;
        1: d = d * 3;
        2: d = d * 5;
        3: d = d * 7;
        4: d = d * 11;
        default: d = d * $urandom_range(13, 40);
      endcase
      if (d > 64'h7fff_ffff) d = d / 2;
    end
    return DenW'(d);
  endfunction

  task automatic add_radix(logic [5:0] r);
    fraction_t f;
    f = plain($urandom, 31'($urandom_range(1, 1000)));
    f.set_radix = 1'b1;
    f.radix = r;
    pending_fractions.push_back(f);
  endtask

  // stimulus
  initial begin
    fraction_t f;
    logic [5:0] radix_set[$];
    pending_fractions.push_back(plain(32'd0, 31'd7));
    pending_fractions.push_back(plain(32'h8000_0000, 31'h7fff_ffff));
    pending_fractions.push_back(plain(32'h7fff_ffff, 31'h7fff_ffff));
    pending_fractions.push_back(plain(32'hffff_ffff, 31'd1));
    pending_fractions.push_back(plain(32'd3, 31'd0));
    pending_fractions.push_back(plain(32'd0, 31'd0));
    pending_fractions.push_back(plain(32'h8000_0000, 31'd0));
    pending_fractions.push_back(plain(32'd1, 31'd3));
    pending_fractions.push_back(plain(-32'sd7, 31'd40));
    pending_fractions.push_back(plain(32'd6, 31'd12));
    pending_fractions.push_back(plain(32'h5555_5555, 31'h2aaa_aaaa));
    pending_fractions.push_back(plain(32'haaaa_aaaa, 31'h5555_5555));
    pending_fractions.push_back(plain(32'd1, 31'h4000_0000));
    radix_set = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd63, 6'd37, 6'd16, 6'd30, 6'd7};
    foreach (radix_set[i]) begin
      add_radix(radix_set[i]);
      pending_fractions.push_back(plain(32'd1, 31'd6));
      pending_fractions.push_back(plain($urandom, smooth_den()));
    end
    for (int i = 0; i < 280; i++) begin
      if (i % 40 == 39) add_radix(6'($urandom));
      if (i == 100) begin
        f = plain(32'd5, 31'd8);
        f.drain = 1'b1;
        pending_fractions.push_back(f);
      end
      case ($urandom_range(0, 5))
        0: f = plain($urandom, 31'($urandom));
        1: f = plain($urandom, 31'($urandom_range(0, 64)));
        2: f = plain(32'($urandom_range(0, 20)) * 32'(smooth_den()), smooth_den());
        default: f = plain($urandom, smooth_den());
      endcase
      pending_fractions.push_back(f);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_radix = 6'd0;
    in_valid = 1'b0;
    in_numerator = '0;
    in_denominator = '0;
    out_ready = 1'b0;
    in_gap = 0;
    out_gap = 0;
    drain_wait = 0;
    radix_now = RadixReset;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    logic write_cfg;
    write_cfg = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_fractions.push_back(reduce_fraction(in_numerator, in_denominator, radix_now));
      end
      if (in_valid && !in_ready) begin
      end else if (pending_fractions.size() == 0) begin
        in_valid <= 1'b0;
        feeding_done <= 1'b1;
      end else if (pending_fractions[0].set_radix || pending_fractions[0].drain) begin
        in_valid <= 1'b0;
        if (expected_fractions.size() != 0 || (in_valid && in_ready)) begin
          drain_wait <= 0;
        end else if (drain_wait < 20) begin
          drain_wait <= drain_wait + 1;
        end else begin
          drain_wait <= 0;
          if (pending_fractions[0].set_radix) begin
            write_cfg = 1'b1;
            cfg_radix <= pending_fractions[0].radix;
            radix_now <= pending_fractions[0].radix;
          end
          pending_fractions[0].set_radix = 1'b0;
          pending_fractions[0].drain = 1'b0;
        end
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_numerator <= pending_fractions[0].num;
        in_denominator <= pending_fractions[0].den;
        void'(pending_fractions.pop_front());
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
    end
    cfg_we <= write_cfg;
  end

  // monitor
  always @(posedge clk) begin
    reduced_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_fractions.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          failed = 1'b1;
        end else begin
          exp_r = expected_fractions.pop_front();
          if (out_finite !== exp_r.finite) begin
            $display("%0t: finite expected %0b actual %0b", $time, exp_r.finite, out_finite);
            failed = 1'b1;
          end
          if (out_reduced_numerator !== exp_r.rnum) begin
            $display("%0t: reduced_numerator expected %0d actual %0d", $time, exp_r.rnum,
                     out_reduced_numerator);
            failed = 1'b1;
          end
          if (out_reduced_denominator !== exp_r.rden) begin
            $display("%0t: reduced_denominator expected %0d actual %0d", $time, exp_r.rden,
                     out_reduced_denominator);
            failed = 1'b1;
          end
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) begin
          out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else if (feeding_done && expected_fractions.size() == 0 && !finishing) begin
      finishing <= 1'b1;
      repeat (50) @(posedge clk);
      if (!failed) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    feeding_done = 1'b0;
    finishing = 1'b0;
    idle_cycles = 0;
  end
endmodule
